/* rtl/quad_dac_command_interface_top_assert.svh */
// Assertion macros used by the quad DAC command interface core.
`ifndef QUAD_DAC_COMMAND_INTERFACE_TOP_ASSERT_SVH
`define QUAD_DAC_COMMAND_INTERFACE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define QDCI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QDCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define QDCI_ASSERT(label, clk, rst_n, prop, msg)
`define QDCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/qdci_pkg.sv */
// Types and constants of the quad DAC command interface.
package qdci_pkg;

    typedef enum logic [1:0] {
        EV_START = 2'd0,
        EV_WRITE = 2'd1,
        EV_READ  = 2'd2,
        EV_STOP  = 2'd3
    } t_bus_cmd;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_OTHER,
        PH_WRITE,
        PH_READ
    } t_phase;

    typedef enum logic [2:0] {
        K_NONE,
        K_FAST,
        K_MULTI,
        K_SEQ,
        K_SINGLE,
        K_PDOWN,
        K_DONE
    } t_kind;

    localparam logic [6:0] BASE_ADDR  = 7'h60;
    localparam logic [1:0] OP_FAST    = 2'b00;
    localparam logic [2:0] OP_VREF    = 3'b100;
    localparam logic [2:0] OP_PDOWN   = 3'b101;
    localparam logic [2:0] OP_GAIN    = 3'b110;
    localparam logic [4:0] OP_MULTI   = 5'b01000;
    localparam logic [4:0] OP_SEQ     = 5'b01010;
    localparam logic [4:0] OP_SINGLE  = 5'b01011;

    typedef struct packed {
        t_bus_cmd   cmd;
        logic [7:0] data_byte;
    } t_event;

    typedef struct packed {
        logic       ack;
        logic [7:0] read_data;
        logic [3:0] updated_mask;
        logic       frame_error;
    } t_result;

endpackage

/* rtl/qdci_core.sv */
// Bus event decoder with channel word storage and readback for the quad DAC interface.
`include "quad_dac_command_interface_top_assert.svh"
module qdci_core #(
    parameter int CHANNELS       = 4,
    parameter int READBACK_BYTES = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_evt_valid,
    input  qdci_pkg::t_event i_evt,
    input  logic [2:0]       i_address_select,
    output qdci_pkg::t_result o_res
);
    import qdci_pkg::*;

    localparam int         CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int         RI_W     = $clog2(READBACK_BYTES);
    localparam logic [2:0] CH_LIMIT = 3'(CHANNELS);
    localparam logic [RI_W-1:0] RB_LAST = RI_W'(READBACK_BYTES - 1);

    t_phase          r_phase, n_phase;
    t_kind           r_kind, n_kind;
    logic [1:0]      r_ch, n_ch;
    logic [1:0]      r_pos, n_pos;
    logic [7:0]      r_held, n_held;
    logic [15:0]     r_reg [CHANNELS];
    logic [15:0]     n_reg [CHANNELS];
    logic [15:0]     r_eep [CHANNELS];
    logic [15:0]     n_eep [CHANNELS];
    logic [RI_W-1:0] r_rd_idx, n_rd_idx;
    logic [1:0]      r_rd_pos, n_rd_pos;
    logic [2:0]      r_rd_tri, n_rd_tri;

    logic [7:0]      b;
    logic [1:0]      op_c;
    logic            op_c_ok;
    logic            addr_hit;
    logic            is_fast, is_vref, is_gain, is_pdown;
    logic            is_multi, is_seq, is_single;
    logic [CH_W-1:0] cur;
    logic            cur_ok;
    logic            ch_last;
    logic [15:0]     word;
    logic [15:0]     fast_word;
    logic [1:0]      pd_val [4];
    logic            wr_reject;
    logic [1:0]      rd_ch;
    logic            rd_ch_ok;
    logic [15:0]     rd_word;
    logic [7:0]      rd_byte;

    assign b         = i_evt.data_byte;
    assign op_c      = b[2:1];
    assign op_c_ok   = ({1'b0, op_c} < CH_LIMIT);
    assign addr_hit  = (b[7:1] == (BASE_ADDR + 7'(i_address_select)));
    assign is_fast   = (b[7:6] == OP_FAST);
    assign is_vref   = (b[7:5] == OP_VREF);
    assign is_gain   = (b[7:5] == OP_GAIN);
    assign is_pdown  = (b[7:5] == OP_PDOWN);
    assign is_multi  = (b[7:3] == OP_MULTI);
    assign is_seq    = (b[7:3] == OP_SEQ);
    assign is_single = (b[7:3] == OP_SINGLE);

    assign cur       = r_ch[CH_W-1:0];
    assign cur_ok    = ({1'b0, r_ch} < CH_LIMIT);
    assign ch_last   = ({1'b0, r_ch} == (CH_LIMIT - 3'd1));
    assign word      = {r_held, b};
    assign fast_word = {r_reg[cur][15], r_held[5:4], r_reg[cur][12], r_held[3:0], b};

    assign pd_val[0] = r_held[3:2];
    assign pd_val[1] = r_held[1:0];
    assign pd_val[2] = b[7:6];
    assign pd_val[3] = b[5:4];

    assign wr_reject = (r_kind == K_DONE)
        || ((r_kind == K_NONE) && !(is_fast || is_vref || is_gain || is_pdown
            || ((is_multi || is_seq || is_single) && op_c_ok)))
        || (((r_kind == K_MULTI) || (r_kind == K_SEQ) || (r_kind == K_SINGLE))
            && (r_pos == 2'd0) && !(is_multi && op_c_ok));

    assign rd_ch    = r_rd_tri[2:1];
    assign rd_ch_ok = ({1'b0, rd_ch} < CH_LIMIT);
    assign rd_word  = !rd_ch_ok ? 16'h0000 :
                      (r_rd_tri[0] ? r_eep[rd_ch[CH_W-1:0]] : r_reg[rd_ch[CH_W-1:0]]);
    assign rd_byte  = (r_rd_pos == 2'd0) ? {2'b10, rd_ch, 4'b0000} :
                      (r_rd_pos == 2'd1) ? rd_word[15:8] : rd_word[7:0];

    always_comb begin
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_ch     = r_ch;
        n_pos    = r_pos;
        n_held   = r_held;
        n_reg    = r_reg;
        n_eep    = r_eep;
        n_rd_idx = r_rd_idx;
        n_rd_pos = r_rd_pos;
        n_rd_tri = r_rd_tri;
        if (i_evt_valid) begin
            unique case (i_evt.cmd)
                EV_START, EV_STOP: begin
                    n_phase = PH_IDLE;
                    n_kind  = K_NONE;
                    n_ch    = 2'd0;
                    n_pos   = 2'd0;
                    n_held  = 8'h00;
                    if (i_evt.cmd == EV_START) begin
                        if (addr_hit) begin
                            if (b[0]) begin
                                n_phase  = PH_READ;
                                n_rd_idx = '0;
                                n_rd_pos = 2'd0;
                                n_rd_tri = 3'd0;
                            end else begin
                                n_phase = PH_WRITE;
                            end
                        end else begin
                            n_phase = PH_OTHER;
                        end
                    end
                end
                EV_WRITE: begin
                    if (r_phase == PH_WRITE) begin
                        unique case (r_kind)
                            K_NONE: begin
                                if (is_fast) begin
                                    n_kind = K_FAST;
                                    n_ch   = 2'd0;
                                    n_held = b;
                                    n_pos  = 2'd1;
                                end else if (is_vref || is_gain) begin
                                    for (int i = 0; i < CHANNELS; i++) begin
                                        if (is_gain) begin
                                            n_reg[i][12] = b[3-i];
                                        end else begin
                                            n_reg[i][15] = b[3-i];
                                        end
                                    end
                                    n_kind = K_DONE;
                                end else if (is_pdown) begin
                                    n_kind = K_PDOWN;
                                    n_held = b;
                                    n_pos  = 2'd1;
                                end else if (is_multi || is_seq || is_single) begin
                                    if (!op_c_ok) begin
                                        n_kind = K_DONE;
                                    end else begin
                                        n_kind = is_multi ? K_MULTI : (is_seq ? K_SEQ : K_SINGLE);
                                        n_ch   = op_c;
                                        n_pos  = 2'd1;
                                    end
                                end else begin
                                    n_kind = K_DONE;
                                end
                            end
                            K_FAST: begin
                                if (r_pos == 2'd0) begin
                                    n_held = b;
                                    n_pos  = 2'd1;
                                end else begin
                                    n_reg[cur] = fast_word;
                                    n_ch       = ch_last ? 2'd0 : r_ch + 2'd1;
                                    n_pos      = 2'd0;
                                end
                            end
                            K_PDOWN: begin
                                for (int i = 0; i < CHANNELS; i++) begin
                                    n_reg[i][14:13] = pd_val[i];
                                end
                                n_kind = K_DONE;
                                n_pos  = 2'd0;
                            end
                            K_MULTI, K_SEQ, K_SINGLE: begin
                                unique case (r_pos)
                                    2'd0: begin
                                        if (is_multi && op_c_ok) begin
                                            n_ch  = op_c;
                                            n_pos = 2'd1;
                                        end
                                    end
                                    2'd1: begin
                                        n_held = b;
                                        n_pos  = 2'd2;
                                    end
                                    default: begin
                                        n_reg[cur] = word;
                                        n_pos      = 2'd0;
                                        if (r_kind != K_MULTI) begin
                                            n_eep[cur] = word;
                                            if ((r_kind == K_SEQ) && !ch_last) begin
                                                n_ch  = r_ch + 2'd1;
                                                n_pos = 2'd1;
                                            end else begin
                                                n_kind = K_DONE;
                                            end
                                        end
                                    end
                                endcase
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                EV_READ: begin
                    if (r_phase == PH_READ) begin
                        if (r_rd_idx == RB_LAST) begin
                            n_rd_idx = '0;
                            n_rd_pos = 2'd0;
                            n_rd_tri = 3'd0;
                        end else begin
                            n_rd_idx = r_rd_idx + RI_W'(1);
                            if (r_rd_pos == 2'd2) begin
                                n_rd_pos = 2'd0;
                                n_rd_tri = r_rd_tri + 3'd1;
                            end else begin
                                n_rd_pos = r_rd_pos + 2'd1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_res = '0;
        if (i_evt_valid) begin
            unique case (i_evt.cmd)
                EV_START, EV_STOP: begin
                    o_res.frame_error = (r_phase == PH_WRITE) && (r_pos != 2'd0);
                    o_res.ack         = (i_evt.cmd == EV_START) && addr_hit;
                end
                EV_WRITE: begin
                    if (r_phase == PH_WRITE) begin
                        o_res.ack         = !wr_reject;
                        o_res.frame_error = wr_reject;
                    end else if (r_phase == PH_READ) begin
                        o_res.frame_error = 1'b1;
                    end
                end
                EV_READ: begin
                    if (r_phase == PH_READ) begin
                        o_res.ack       = 1'b1;
                        o_res.read_data = rd_byte;
                    end else if (r_phase == PH_WRITE) begin
                        o_res.frame_error = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            for (int i = 0; i < CHANNELS; i++) begin
                o_res.updated_mask[i] = (n_reg[i] != r_reg[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_kind   <= K_NONE;
            r_ch     <= 2'd0;
            r_pos    <= 2'd0;
            r_held   <= 8'h00;
            r_rd_idx <= '0;
            r_rd_pos <= 2'd0;
            r_rd_tri <= 3'd0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_reg[i] <= 16'h0000;
                r_eep[i] <= 16'h0000;
            end
        end else begin
            r_phase  <= n_phase;
            r_kind   <= n_kind;
            r_ch     <= n_ch;
            r_pos    <= n_pos;
            r_held   <= n_held;
            r_rd_idx <= n_rd_idx;
            r_rd_pos <= n_rd_pos;
            r_rd_tri <= n_rd_tri;
            r_reg    <= n_reg;
            r_eep    <= n_eep;
        end
    end

    `QDCI_ASSERT(a_done_no_partial, i_clk, i_rst_n, (r_kind == K_DONE) |-> (r_pos == 2'd0), "Finished command still holds a partial byte.")
    `QDCI_ASSERT(a_kind_only_in_write, i_clk, i_rst_n, (r_phase != PH_WRITE) |-> (r_kind == K_NONE), "Command state outside a write transfer.")
    `QDCI_ASSERT(a_channel_in_range, i_clk, i_rst_n, cur_ok, "Current channel beyond the channel count.")
    `QDCI_ASSERT(a_mask_on_accepted_write, i_clk, i_rst_n, (i_evt_valid && (o_res.updated_mask != 4'd0)) |-> ((i_evt.cmd == EV_WRITE) && o_res.ack), "Channel update without an accepted write.")
    `QDCI_ASSERT_NEXT(a_stop_goes_idle, i_clk, i_rst_n, (i_evt_valid && (i_evt.cmd == EV_STOP)), (r_phase == PH_IDLE), "Stop did not return the bus to idle.")

endmodule

/* rtl/quad_dac_command_interface_top.sv */
// Top level of the quad DAC command interface with input and result registers.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+----------------------------------------------
//  event in | i_in_valid / o_in_ready    | i_cmd, i_data_byte
//  result   | o_out_valid / i_out_ready  | o_ack, o_read_data, o_updated_mask, o_frame_error
//  config   | i_cfg_we                   | i_cfg_wdata
//
// One event transfer per cycle while results are taken; each passes the input and result registers.
// The decode of one event sits between the input register and the result register.
// Reset clears the bus state, both channel copies and the address select register.
// A stalled result holds the result register, and the input register then holds one more event.
module quad_dac_command_interface_top #(
    parameter int CHANNELS       = 4,
    parameter int READBACK_BYTES = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_data_byte,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_ack,
    output logic [7:0] o_read_data,
    output logic [3:0] o_updated_mask,
    output logic       o_frame_error
);
    import qdci_pkg::*;

    logic [2:0] r_address_select;
    logic       r_in_valid;
    t_event     r_in_evt;
    logic       r_out_valid;
    t_result    r_out_res;
    t_result    core_res;
    logic       advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    qdci_core #(
        .CHANNELS       (CHANNELS),
        .READBACK_BYTES (READBACK_BYTES)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_evt_valid      (advance),
        .i_evt            (r_in_evt),
        .i_address_select (r_address_select),
        .o_res            (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_select <= 3'd0;
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_address_select <= i_cfg_wdata;
            end
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_evt.cmd       <= t_bus_cmd'(i_cmd);
            r_in_evt.data_byte <= i_data_byte;
        end
        if (advance) begin
            r_out_res <= core_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_ack          = r_out_res.ack;
    assign o_read_data    = r_out_res.read_data;
    assign o_updated_mask = r_out_res.updated_mask;
    assign o_frame_error  = r_out_res.frame_error;

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the quad DAC command interface: bus events in, checked replies out.
`timescale 1ns / 1ps

module testbench;
    import qdci_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       ev_valid = 1'b0;
    logic       ev_ready;
    logic [1:0] ev_cmd = EV_STOP;
    logic [7:0] ev_byte = 8'h00;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_wdata = 3'd0;
    logic       rep_valid;
    logic       rep_ready = 1'b1;
    logic       rep_ack;
    logic [7:0] rep_read_data;
    logic [3:0] rep_updated_mask;
    logic       rep_frame_error;

    t_result    pending_replies[$];
    int         error_count = 0;
    int         reply_count = 0;
    int         events_sent = 0;
    int         cycle_count = 0;
    bit         idle_on = 1'b1;
    bit         sender_calm = 1'b0;

    t_phase      bus_phase;
    t_kind       cmd_kind;
    logic [1:0]  cur_chan;
    logic [1:0]  byte_pos;
    logic [7:0]  held;
    logic [15:0] reg_words[4];
    logic [15:0] eeprom_words[4];
    logic [4:0]  rd_idx;
    logic [2:0]  addr_sel;

    quad_dac_command_interface_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (ev_valid),
        .o_in_ready     (ev_ready),
        .i_cmd          (ev_cmd),
        .i_data_byte    (ev_byte),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .o_out_valid    (rep_valid),
        .i_out_ready    (rep_ready),
        .o_ack          (rep_ack),
        .o_read_data    (rep_read_data),
        .o_updated_mask (rep_updated_mask),
        .o_frame_error  (rep_frame_error)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic void reset_model();
        int i;
        bus_phase = PH_IDLE;
        cmd_kind = K_NONE;
        cur_chan = 2'd0;
        byte_pos = 2'd0;
        held = 8'h00;
        rd_idx = 5'd0;
        addr_sel = 3'd0;
        for (i = 0; i < 4; i++) begin
            reg_words[i] = 16'h0000;
            eeprom_words[i] = 16'h0000;
        end
    endfunction

    function automatic logic [3:0] store_word(logic [1:0] ch, logic [15:0] w);
        logic [3:0] m;
        m = 4'h0;
        m[ch] = (reg_words[ch] != w);
        reg_words[ch] = w;
        return m;
    endfunction

    function automatic bit apply_write_byte(logic [7:0] b, output logic [3:0] m);
        logic [1:0]  ch;
        logic [15:0] w;
        logic [7:0]  pd_all;
        int          i;
        ch = cur_chan;
        m = 4'h0;
        if (cmd_kind == K_DONE) return 1'b0;
        if (cmd_kind == K_NONE) begin
            if (b[7:6] == OP_FAST) begin
                cmd_kind = K_FAST;
                cur_chan = 2'd0;
                held = b;
                byte_pos = 2'd1;
                return 1'b1;
            end
            if (b[7:5] == OP_VREF || b[7:5] == OP_GAIN) begin
                for (i = 0; i < 4; i++) begin
                    w = reg_words[i];
                    if (b[7:5] == OP_GAIN) w[12] = b[3 - i];
                    else w[15] = b[3 - i];
                    m |= store_word(2'(i), w);
                end
                cmd_kind = K_DONE;
                return 1'b1;
            end
            if (b[7:5] == OP_PDOWN) begin
                cmd_kind = K_PDOWN;
                held = b;
                byte_pos = 2'd1;
                return 1'b1;
            end
            if (b[7:3] == OP_MULTI || b[7:3] == OP_SEQ || b[7:3] == OP_SINGLE) begin
                cmd_kind = (b[7:3] == OP_MULTI) ? K_MULTI :
                           (b[7:3] == OP_SEQ) ? K_SEQ : K_SINGLE;
                cur_chan = b[2:1];
                byte_pos = 2'd1;
                return 1'b1;
            end
            cmd_kind = K_DONE;
            return 1'b0;
        end
        if (cmd_kind == K_FAST) begin
            if (byte_pos == 2'd0) begin
                held = b;
                byte_pos = 2'd1;
                return 1'b1;
            end
            m = store_word(ch, {reg_words[ch][15], held[5:4], reg_words[ch][12], held[3:0], b});
            cur_chan = ch + 2'd1;
            byte_pos = 2'd0;
            return 1'b1;
        end
        if (cmd_kind == K_PDOWN) begin
            pd_all = {held[3:0], b[7:4]};
            for (i = 0; i < 4; i++) begin
                w = reg_words[i];
                w[14:13] = pd_all[7 - 2 * i -: 2];
                m |= store_word(2'(i), w);
            end
            cmd_kind = K_DONE;
            byte_pos = 2'd0;
            return 1'b1;
        end
        if (byte_pos == 2'd0) begin
            if (b[7:3] != OP_MULTI) return 1'b0;
            cur_chan = b[2:1];
            byte_pos = 2'd1;
            return 1'b1;
        end
        if (byte_pos == 2'd1) begin
            held = b;
            byte_pos = 2'd2;
            return 1'b1;
        end
        w = {held, b};
        m = store_word(ch, w);
        byte_pos = 2'd0;
        if (cmd_kind == K_MULTI) return 1'b1;
        eeprom_words[ch] = w;
        if (cmd_kind == K_SEQ && ch != 2'd3) begin
            cur_chan = ch + 2'd1;
            byte_pos = 2'd1;
        end else begin
            cmd_kind = K_DONE;
        end
        return 1'b1;
    endfunction

    function automatic t_result decode_bus_event(t_bus_cmd c, logic [7:0] b);
        t_result     r;
        logic [3:0]  m;
        logic [1:0]  ch;
        logic [15:0] w;
        int          t;
        int          pos;
        r = '0;
        m = 4'h0;
        case (c)
            EV_START, EV_STOP: begin
                if (bus_phase == PH_WRITE && byte_pos != 2'd0) r.frame_error = 1'b1;
                bus_phase = PH_IDLE;
                cmd_kind = K_NONE;
                cur_chan = 2'd0;
                byte_pos = 2'd0;
                held = 8'h00;
                if (c == EV_START) begin
                    if (b[7:1] == BASE_ADDR + 7'(addr_sel)) begin
                        r.ack = 1'b1;
                        if (b[0]) begin
                            bus_phase = PH_READ;
                            rd_idx = 5'd0;
                        end else begin
                            bus_phase = PH_WRITE;
                        end
                    end else begin
                        bus_phase = PH_OTHER;
                    end
                end
            end
            EV_WRITE: begin
                if (bus_phase == PH_WRITE) begin
                    if (apply_write_byte(b, m)) r.ack = 1'b1;
                    else r.frame_error = 1'b1;
                    r.updated_mask = m;
                end else if (bus_phase == PH_READ) begin
                    r.frame_error = 1'b1;
                end
            end
            default: begin
                if (bus_phase == PH_READ) begin
                    t = rd_idx / 3;
                    pos = rd_idx % 3;
                    ch = 2'(t >> 1);
                    w = t[0] ? eeprom_words[ch] : reg_words[ch];
                    if (pos == 0) r.read_data = 8'h80 | {2'b00, ch, 4'h0};
                    else if (pos == 1) r.read_data = w[15:8];
                    else r.read_data = w[7:0];
                    r.ack = 1'b1;
                    rd_idx = (rd_idx == 5'd23) ? 5'd0 : rd_idx + 5'd1;
                end else if (bus_phase == PH_WRITE) begin
                    r.frame_error = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on reply %0d, %s: got 0x%0h, expected 0x%0h",
                 reply_count, what, got, want);
        error_count++;
    endtask

    always @(posedge clk) begin : check_results
        t_result want;
        if (rst_n && rep_valid && rep_ready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("reply with no event pending", 0, 0);
            end else begin
                want = pending_replies.pop_front();
                if (rep_ack !== want.ack)
                    report_mismatch("ack", rep_ack, want.ack);
                if (rep_read_data !== want.read_data)
                    report_mismatch("read_data", rep_read_data, want.read_data);
                if (rep_updated_mask !== want.updated_mask)
                    report_mismatch("updated_mask", rep_updated_mask, want.updated_mask);
                if (rep_frame_error !== want.frame_error)
                    report_mismatch("frame_error", rep_frame_error, want.frame_error);
            end
            reply_count++;
        end
    end

    initial begin
        forever begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                rep_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                rep_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) repeat ($urandom_range(30, 120)) @(posedge clk);
            end
        end
    end

    task automatic send_event(t_bus_cmd c, logic [7:0] b);
        if (idle_on && !sender_calm && $urandom_range(0, 9) == 0) begin
            ev_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        ev_valid <= 1'b1;
        ev_cmd <= c;
        ev_byte <= b;
        @(posedge clk);
        while (!ev_ready) @(posedge clk);
        pending_replies.push_back(decode_bus_event(c, b));
        events_sent++;
    endtask

    task automatic wait_idle();
        ev_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
    endtask

    task automatic write_address_select(logic [2:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        addr_sel = v;
    endtask

    function automatic logic [7:0] addr_byte(bit rd);
        return {BASE_ADDR + 7'(addr_sel), rd};
    endfunction

    task automatic test_fast_write();
        send_event(EV_START, addr_byte(1'b0));
        send_event(EV_WRITE, 8'h3F);
        send_event(EV_WRITE, 8'hFF);
        send_event(EV_WRITE, 8'hC5);
        send_event(EV_STOP, 8'hFF);
    endtask

    task automatic test_group_writes();
        send_event(EV_START, addr_byte(1'b0));
        send_event(EV_WRITE, {OP_MULTI, 2'd3, 1'b0});
        send_event(EV_WRITE, 8'h9A);
        send_event(EV_WRITE, 8'hBC);
        send_event(EV_WRITE, {OP_SEQ, 2'd0, 1'b0});
        send_event(EV_START, addr_byte(1'b0));
        send_event(EV_WRITE, {OP_SINGLE, 2'd1, 1'b1});
        send_event(EV_WRITE, 8'hFF);
        send_event(EV_READ, 8'h00);
        send_event(EV_WRITE, 8'hFF);
        send_event(EV_WRITE, 8'h00);
        send_event(EV_START, addr_byte(1'b0));
        send_event(EV_WRITE, {OP_SEQ, 2'd2, 1'b0});
        send_event(EV_WRITE, 8'h12);
        send_event(EV_WRITE, 8'h34);
        send_event(EV_WRITE, 8'h56);
        send_event(EV_WRITE, 8'h78);
    endtask

    task automatic test_select_commands();
        send_event(EV_START, addr_byte(1'b0));
        send_event(EV_WRITE, {OP_VREF, 5'h1F});
        send_event(EV_START, addr_byte(1'b0));
        send_event(EV_WRITE, {OP_GAIN, 5'h15});
        send_event(EV_START, addr_byte(1'b0));
        send_event(EV_WRITE, {OP_PDOWN, 5'h16});
        send_event(EV_WRITE, 8'hA0);
    endtask

    task automatic test_bus_errors();
        send_event(EV_START, addr_byte(1'b0));
        send_event(EV_WRITE, 8'h60);
        send_event(EV_WRITE, 8'h00);
        send_event(EV_START, {BASE_ADDR + 7'(addr_sel) + 7'd1, 1'b0});
        send_event(EV_WRITE, 8'h00);
        send_event(EV_START, addr_byte(1'b1));
        send_event(EV_READ, 8'h00);
        send_event(EV_WRITE, 8'h55);
        send_event(EV_STOP, 8'h00);
    endtask

    task automatic random_transfer();
        logic [7:0] body[$];
        int         n;
        int         c;
        int         i;
        sender_calm = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
            0: begin
                n = $urandom_range(1, 4);
                repeat (n) send_event(t_bus_cmd'($urandom_range(0, 3)), 8'($urandom));
                return;
            end
            1, 2: begin
                send_event(EV_START, ($urandom_range(0, 9) == 0) ? 8'($urandom) : addr_byte(1'b1));
                n = $urandom_range(1, 30);
                for (i = 0; i < n; i++)
                    send_event(($urandom_range(0, 19) == 0) ? EV_WRITE : EV_READ, 8'($urandom));
                if ($urandom_range(0, 3) != 0) send_event(EV_STOP, 8'($urandom));
                return;
            end
            default: ;
        endcase
        case ($urandom_range(0, 6))
            0: begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) begin
                    body.push_back((i == 0) ? {OP_FAST, 6'($urandom)} : 8'($urandom));
                    body.push_back(8'($urandom));
                end
            end
            1: begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    body.push_back({OP_MULTI, 2'($urandom), 1'($urandom)});
                    body.push_back(8'($urandom));
                    body.push_back(8'($urandom));
                end
            end
            2: begin
                c = $urandom_range(0, 3);
                body.push_back({OP_SEQ, 2'(c), 1'($urandom)});
                repeat (2 * (4 - c)) body.push_back(8'($urandom));
            end
            3: begin
                body.push_back({OP_SINGLE, 2'($urandom), 1'($urandom)});
                body.push_back(8'($urandom));
                body.push_back(8'($urandom));
            end
            4: body.push_back({($urandom_range(0, 1) == 0) ? OP_VREF : OP_GAIN, 5'($urandom)});
            5: begin
                body.push_back({OP_PDOWN, 5'($urandom)});
                body.push_back(8'($urandom));
            end
            default: begin
                n = $urandom_range(1, 4);
                repeat (n) body.push_back(8'($urandom));
            end
        endcase
        case ($urandom_range(0, 9))
            0: if (body.size() > 1) void'(body.pop_back());
            1: body.push_back(8'($urandom));
            2: body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
            default: ;
        endcase
        send_event(EV_START, ($urandom_range(0, 9) == 0) ? 8'($urandom) : addr_byte(1'b0));
        foreach (body[i]) begin
            if ($urandom_range(0, 32) == 0) send_event(EV_READ, 8'($urandom));
            send_event(EV_WRITE, body[i]);
        end
        if ($urandom_range(0, 3) != 0) send_event(EV_STOP, 8'($urandom));
    endtask

    task automatic test_random_traffic(int target);
        int first;
        first = events_sent;
        while (events_sent - first < target) random_transfer();
    endtask

    initial begin
        reset_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        write_address_select(3'd0);
        test_fast_write();
        test_group_writes();
        test_select_commands();
        test_bus_errors();
        wait_idle();
        write_address_select(3'd7);
        test_random_traffic(190);
        wait_idle();
        write_address_select(3'($urandom));
        test_random_traffic(190);
        wait_idle();
        write_address_select(3'd0);
        test_random_traffic(190);
        wait_idle();
        write_address_select(3'($urandom));
        test_random_traffic(190);
        wait_idle();
        idle_on = 1'b0;
        write_address_select(3'($urandom));
        test_random_traffic(190);
        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
